[hw/rtl/qpv_pkg.sv]
// qpv_pkg: shared widths, register indexes and reset values for the
// quadrature position/velocity block. No dependencies.
package qpv_pkg;

    localparam int AXES_DEFAULT   = 3;
    localparam int TIME_W_DEFAULT = 48;

    localparam int AXIS_W    = 2;
    localparam int POS_W     = 32;
    localparam int RATE_W    = 20;
    localparam int TIMEOUT_W = 24;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 1;

    // counts per second = counts * 1e6 / microseconds
    localparam logic [RATE_W-1:0] RATE_SCALE = 20'd1000000;

    localparam logic [CFG_IDX_W-1:0] REG_AXIS_ENABLE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STILL_TIMEOUT = 1'd1;

    localparam logic [7:0]           ENABLE_RESET  = 8'h07;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd200000;

endpackage

[hw/rtl/quadrature_position_velocity.sv]
// quadrature_position_velocity: per-axis 4x quadrature decoder with position,
// velocity and index latch. Uses qpv_pkg and qpv_div.
//
//  channel | direction | ports                          | word accepted when
//  --------+-----------+--------------------------------+--------------------
//  sample  | in        | s_valid/s_ready, s_* fields    | s_valid & s_ready
//  result  | out       | m_valid/m_ready, m_* fields    | m_valid & m_ready
//  config  | in        | cfg_wr_en/index/data           | cfg_wr_en
//
// One word at a time: after accept a word passes the decode stage, then the evaluate
// stage when a velocity update is asked, then multiply and divide when a divide
// follows, and write-back (the divider retires one of 52 quotient bits per cycle).
// Axis state lives in one record memory, read on accept and written back at
// the end; per-axis valid bits make unwritten entries read as zero after reset.
// A new word is taken while the previous result waits in the output register;
// write-back waits until that register is free.
module quadrature_position_velocity #(
    parameter int AXES       = qpv_pkg::AXES_DEFAULT,
    parameter int TIME_WIDTH = qpv_pkg::TIME_W_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_wr_en,
    input  logic [qpv_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [qpv_pkg::CFG_W-1:0]   cfg_wr_data,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [qpv_pkg::AXIS_W-1:0]  s_axis,
    input  logic                        s_sig_a,
    input  logic                        s_sig_b,
    input  logic                        s_sig_index,
    input  logic [TIME_WIDTH-1:0]       s_time_us,
    input  logic                        s_vel_update,
    input  logic                        s_load_pos,
    input  logic signed [qpv_pkg::POS_W-1:0] s_load_value,
    input  logic                        s_take_index,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [qpv_pkg::AXIS_W-1:0]  m_out_axis,
    output logic signed [qpv_pkg::POS_W-1:0] m_position,
    output logic signed [qpv_pkg::POS_W-1:0] m_velocity,
    output logic                        m_index_seen
);

    import qpv_pkg::*;

    localparam int AW    = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int EN_W  = (AXES < 4) ? AXES : 4;
    localparam int NUM_W = POS_W + RATE_W;
    localparam int TW    = TIME_WIDTH;

    localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(64'h8000_0000);
    localparam logic [NUM_W-1:0] POS_LIM = NUM_W'(64'h7FFF_FFFF);

    typedef struct packed {
        logic [2:0]       prev;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] psnap;
        logic [TW-1:0]    tsnap;
        logic [TW-1:0]    lmt;
        logic [POS_W-1:0] vel;
        logic             flag;
    } rec_t;

    typedef enum logic [2:0] {
        S_IDLE, S_DEC, S_EVAL, S_MUL, S_DSTART, S_DWAIT, S_WB
    } state_t;

    state_t state_reg;

    // config
    logic [EN_W-1:0]      en_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    // captured word
    logic [AXIS_W-1:0] axis_reg;
    logic              a_reg, b_reg, z_reg;
    logic [TW-1:0]     time_reg;
    logic              vup_reg, load_reg, take_reg;
    logic [POS_W-1:0]  lval_reg;
    logic              in_rng_reg;

    // record memory
    rec_t              mem [AXES];
    rec_t              rd_data_reg;
    logic              rd_vld_reg;
    logic [AXES-1:0]   vld_reg;

    // work record and datapath registers
    rec_t              wrk_reg;
    logic              active_reg;
    logic              seen_reg;
    logic [POS_W-1:0]  dpos_reg;
    logic [TW-1:0]     dt_reg;
    logic [NUM_W-1:0]  prod_reg;

    logic              out_free;
    logic              accept;
    logic              mem_we;
    logic              in_rng_s;
    logic [AW-1:0]     widx;

    logic              div_start;
    logic              div_done;
    logic [NUM_W-1:0]  div_quot;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid || m_ready;
    assign in_rng_s = (32'(s_axis) < AXES);
    assign widx     = AW'(axis_reg);
    assign mem_we   = (state_reg == S_WB) && out_free && in_rng_reg;
    assign div_start = (state_reg == S_DSTART);

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= mem[AW'(s_axis)];
        end
        if (mem_we) begin
            mem[widx] <= wrk_reg;
        end
    end

    // ---- decode stage: edges, Z latch, load, index take
    rec_t             rec_cur;
    rec_t             dec_next;
    logic             seen_next;
    logic             enabled;
    logic [3:0]       en4;
    logic             pa, pb, pz;

    always_comb begin
        en4      = 4'(en_reg);
        enabled  = en4[axis_reg];
        rec_cur  = rd_vld_reg ? rd_data_reg : '0;
        pa       = rec_cur.prev[0];
        pb       = rec_cur.prev[1];
        pz       = rec_cur.prev[2];
        dec_next = rec_cur;
        seen_next = 1'b0;
        dec_next.prev = {z_reg, b_reg, a_reg};
        if (enabled) begin
            if (a_reg != pa && b_reg == pb) begin
                dec_next.pos = (a_reg ^ b_reg) ? rec_cur.pos + 32'd1
                                               : rec_cur.pos - 32'd1;
            end else if (b_reg != pb && a_reg == pa) begin
                dec_next.pos = (a_reg ^ b_reg) ? rec_cur.pos - 32'd1
                                               : rec_cur.pos + 32'd1;
            end
            if (z_reg && !pz) begin
                dec_next.flag = 1'b1;
            end
            if (load_reg) begin
                dec_next.pos   = lval_reg;
                dec_next.psnap = lval_reg;
                dec_next.tsnap = time_reg;
                dec_next.lmt   = time_reg;
                dec_next.vel   = '0;
            end
            // take is last in order; the flag seen here already has this Z edge
            if (take_reg) begin
                seen_next     = dec_next.flag;
                dec_next.flag = 1'b0;
            end
        end
    end

    // ---- evaluate stage: time step, position change, stillness
    logic [TW-1:0]    dt;
    logic [TW-1:0]    idle;
    logic [POS_W-1:0] dpos;
    logic             dt_pos;
    logic             still;
    logic             moved;

    always_comb begin
        dt     = time_reg - wrk_reg.tsnap;
        dt_pos = (dt != '0) && !dt[TW-1];
        dpos   = wrk_reg.pos - wrk_reg.psnap;
        moved  = (dpos != '0);
        idle   = moved ? '0 : (time_reg - wrk_reg.lmt);
        still  = (idle != '0) && !idle[TW-1] && (idle > TW'(timeout_reg));
    end

    // ---- multiply and saturate
    logic [POS_W-1:0] mag;
    logic [NUM_W-1:0] mul_prod;
    logic [POS_W-1:0] vel_sat;

    always_comb begin
        mag      = dpos_reg[POS_W-1] ? (~dpos_reg + 32'd1) : dpos_reg;
        mul_prod = NUM_W'(mag) * NUM_W'(RATE_SCALE);
        if (dpos_reg[POS_W-1]) begin
            vel_sat = (div_quot > NEG_LIM) ? 32'h8000_0000
                                           : (~div_quot[POS_W-1:0] + 32'd1);
        end else begin
            vel_sat = (div_quot > POS_LIM) ? 32'h7FFF_FFFF : div_quot[POS_W-1:0];
        end
    end

    qpv_div #(
        .NUM_W (NUM_W),
        .DEN_W (TW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (prod_reg),
        .den     (dt_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // ---- control, config and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid     <= 1'b0;
            vld_reg     <= '0;
            en_reg      <= ENABLE_RESET[EN_W-1:0];
            timeout_reg <= TIMEOUT_RESET;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_AXIS_ENABLE:   en_reg      <= cfg_wr_data[EN_W-1:0];
                    REG_STILL_TIMEOUT: timeout_reg <= cfg_wr_data[TIMEOUT_W-1:0];
                    default: ;
                endcase
            end
            // a write-back in the same cycle reloads the register instead
            if (m_valid && m_ready && state_reg != S_WB) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        axis_reg   <= s_axis;
                        a_reg      <= s_sig_a;
                        b_reg      <= s_sig_b;
                        z_reg      <= s_sig_index;
                        time_reg   <= s_time_us;
                        vup_reg    <= s_vel_update;
                        load_reg   <= s_load_pos;
                        lval_reg   <= s_load_value;
                        take_reg   <= s_take_index;
                        in_rng_reg <= in_rng_s;
                        rd_vld_reg <= in_rng_s && vld_reg[AW'(s_axis)];
                        state_reg  <= S_DEC;
                    end
                end
                S_DEC: begin
                    wrk_reg    <= dec_next;
                    seen_reg   <= seen_next;
                    active_reg <= in_rng_reg && enabled;
                    state_reg  <= (in_rng_reg && enabled && vup_reg) ? S_EVAL : S_WB;
                end
                S_EVAL: begin
                    dpos_reg <= dpos;
                    dt_reg   <= dt;
                    if (dt_pos) begin
                        wrk_reg.psnap <= wrk_reg.pos;
                        wrk_reg.tsnap <= time_reg;
                        if (moved) begin
                            wrk_reg.lmt <= time_reg;
                        end
                        if (still) begin
                            wrk_reg.vel <= '0;
                            state_reg   <= S_WB;
                        end else begin
                            state_reg   <= S_MUL;
                        end
                    end else begin
                        state_reg <= S_WB;
                    end
                end
                S_MUL: begin
                    prod_reg  <= mul_prod;
                    state_reg <= S_DSTART;
                end
                S_DSTART: begin
                    state_reg <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_done) begin
                        wrk_reg.vel <= vel_sat;
                        state_reg   <= S_WB;
                    end
                end
                S_WB: begin
                    if (out_free) begin
                        if (in_rng_reg) begin
                            vld_reg[widx] <= 1'b1;
                        end
                        m_valid      <= 1'b1;
                        m_out_axis   <= axis_reg;
                        m_position   <= active_reg ? wrk_reg.pos : '0;
                        m_velocity   <= active_reg ? wrk_reg.vel : '0;
                        m_index_seen <= active_reg && seen_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_result_from_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_WB))
        else $error("result raised outside write-back");
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted while one is in flight");
    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DWAIT)
        else $error("divider finished outside its wait state");
    a_div_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> dt_reg != '0 && !dt_reg[TW-1])
        else $error("divide started with a non-positive time step");
`endif

endmodule

[hw/rtl/qpv_div.sv]
// qpv_div: unsigned restoring divider, one quotient bit per cycle.
// Standalone; used by quadrature_position_velocity for the velocity estimate.
module qpv_div #(
    parameter int NUM_W = 52,
    parameter int DEN_W = 48
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;

    logic [DEN_W-1:0] shl;
    logic             ge;
    logic [DEN_W-1:0] rem_next;

    // divisor stays below 2^(DEN_W-1), so the shifted remainder fits DEN_W bits
    always_comb begin
        shl      = {rem_reg[DEN_W-2:0], quo_reg[NUM_W-1]};
        ge       = (shl >= den_reg);
        rem_next = ge ? (shl - den_reg) : shl;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("divider done without a running division");
    a_busy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with empty count");
`endif

endmodule

[dv/qpv_result_checker.sv]
// qpv_result_checker: watches the sample, result and config ports of the
// quadrature position/velocity block, predicts each result word and compares it.
// Depends on qpv_pkg.
module qpv_result_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [qpv_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [qpv_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [qpv_pkg::AXIS_W-1:0]    s_axis,
    input  logic                 s_sig_a,
    input  logic                 s_sig_b,
    input  logic                 s_sig_index,
    input  logic [qpv_pkg::TIME_W_DEFAULT-1:0] s_time_us,
    input  logic                 s_vel_update,
    input  logic                 s_load_pos,
    input  logic [qpv_pkg::POS_W-1:0]     s_load_value,
    input  logic                 s_take_index,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [qpv_pkg::AXIS_W-1:0]    m_out_axis,
    input  logic [qpv_pkg::POS_W-1:0]     m_position,
    input  logic [qpv_pkg::POS_W-1:0]     m_velocity,
    input  logic                 m_index_seen,
    output int                   fail_count,
    output int                   outstanding,
    output int                   compared
);

    import qpv_pkg::*;

    localparam int NAX = AXES_DEFAULT;
    localparam int TW  = TIME_W_DEFAULT;

    typedef struct packed {
        logic [AXIS_W-1:0] axis;
        logic [POS_W-1:0]  position;
        logic [POS_W-1:0]  velocity;
        logic              index_seen;
    } axis_report_t;

    logic [7:0]           enable_mask;
    logic [TIMEOUT_W-1:0] still_limit;
    logic [2:0]           pin_levels [NAX];
    logic [POS_W-1:0]     pos_count  [NAX];
    logic [POS_W-1:0]     pos_base   [NAX];
    logic [TW-1:0]        time_snap  [NAX];
    logic [TW-1:0]        last_move  [NAX];
    logic [POS_W-1:0]     rate_est   [NAX];
    logic                 index_flag [NAX];

    axis_report_t awaited_reports [$];
    axis_report_t oldest;

    // wrapped difference read as a signed TW-bit value, strictly positive
    function automatic bit is_after(input logic [TW-1:0] d);
        return d != '0 && !d[TW-1];
    endfunction

    function automatic axis_report_t decode_word(
        input logic [AXIS_W-1:0] ax,
        input logic              a,
        input logic              b,
        input logic              z,
        input logic [TW-1:0]     now,
        input logic              vup,
        input logic              load,
        input logic [POS_W-1:0]  lval,
        input logic              take
    );
        axis_report_t r;
        logic         pa, pb, pz;
        logic         up;
        logic [TW-1:0]    dt, idle;
        logic [POS_W-1:0] dpos;
        longint       q;
        r = '0;
        r.axis = ax;
        if (ax >= NAX) return r;
        {pz, pb, pa} = pin_levels[ax];
        // disabled axes still track pins so re-enabling sees no phantom edge
        pin_levels[ax] = {z, b, a};
        if (!enable_mask[ax]) return r;

        if (a != pa && b == pb) begin
            up = a ^ b;
            pos_count[ax] += up ? 32'd1 : 32'hFFFF_FFFF;
        end else if (b != pb && a == pa) begin
            up = (a == b);
            pos_count[ax] += up ? 32'd1 : 32'hFFFF_FFFF;
        end
        if (z && !pz) index_flag[ax] = 1'b1;

        if (load) begin
            pos_count[ax] = lval;
            pos_base[ax]  = lval;
            time_snap[ax] = now;
            last_move[ax] = now;
            rate_est[ax]  = '0;
        end

        if (vup) begin
            dt = now - time_snap[ax];
            if (is_after(dt)) begin
                dpos = pos_count[ax] - pos_base[ax];
                if (dpos != '0) last_move[ax] = now;
                idle = now - last_move[ax];
                if (is_after(idle) && idle > TW'(still_limit)) begin
                    rate_est[ax] = '0;
                end else begin
                    q = longint'(signed'(dpos)) * 64'sd1000000 / longint'(dt);
                    if (q > 64'sd2147483647) q = 64'sd2147483647;
                    if (q < -64'sd2147483648) q = -64'sd2147483648;
                    rate_est[ax] = q[31:0];
                end
                pos_base[ax]  = pos_count[ax];
                time_snap[ax] = now;
            end
        end

        if (take) begin
            r.index_seen = index_flag[ax];
            index_flag[ax] = 1'b0;
        end
        r.position = pos_count[ax];
        r.velocity = rate_est[ax];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (fail_count < 100)
            $display("[%0t] MISMATCH %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            enable_mask = ENABLE_RESET;
            still_limit = TIMEOUT_RESET;
            for (int i = 0; i < NAX; i++) begin
                pin_levels[i] = '0;
                pos_count[i]  = '0;
                pos_base[i]   = '0;
                time_snap[i]  = '0;
                last_move[i]  = '0;
                rate_est[i]   = '0;
                index_flag[i] = 1'b0;
            end
            awaited_reports.delete();
            outstanding = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_wr_index == REG_AXIS_ENABLE)
                    enable_mask = cfg_wr_data[7:0];
                else if (cfg_wr_index == REG_STILL_TIMEOUT)
                    still_limit = cfg_wr_data[TIMEOUT_W-1:0];
            end
            // result word retires before a same-edge sample word is predicted
            if (m_valid && m_ready) begin
                if (awaited_reports.size() == 0) begin
                    report_mismatch("result word with none awaited", '0, m_position);
                end else begin
                    oldest = awaited_reports.pop_front();
                    if (m_out_axis !== oldest.axis)
                        report_mismatch("out_axis", 32'(oldest.axis), 32'(m_out_axis));
                    if (m_position !== oldest.position)
                        report_mismatch("position", oldest.position, m_position);
                    if (m_velocity !== oldest.velocity)
                        report_mismatch("velocity", oldest.velocity, m_velocity);
                    if (m_index_seen !== oldest.index_seen)
                        report_mismatch("index_seen", 32'(oldest.index_seen),
                                        32'(m_index_seen));
                    compared++;
                end
            end
            if (s_valid && s_ready)
                awaited_reports.push_back(decode_word(s_axis, s_sig_a, s_sig_b,
                    s_sig_index, s_time_us, s_vel_update, s_load_pos, s_load_value,
                    s_take_index));
            outstanding = awaited_reports.size();
        end
    end

endmodule

[dv/tb.sv]
// tb: stimulus and verdict for quadrature_position_velocity. Drives directed
// and random sample words; qpv_result_checker does the prediction.
// Depends on qpv_pkg, quadrature_position_velocity and qpv_result_checker.
module tb;
    import qpv_pkg::*;

    localparam int TW = TIME_W_DEFAULT;

    typedef enum int {RX_OPEN, RX_CHOPPY, RX_SLOW} rx_mode_e;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_wr_index;
    logic [CFG_W-1:0]     cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [AXIS_W-1:0]    s_axis;
    logic                 s_sig_a;
    logic                 s_sig_b;
    logic                 s_sig_index;
    logic [TW-1:0]        s_time_us;
    logic                 s_vel_update;
    logic                 s_load_pos;
    logic [POS_W-1:0]     s_load_value;
    logic                 s_take_index;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [AXIS_W-1:0]    m_out_axis;
    logic [POS_W-1:0]     m_position;
    logic [POS_W-1:0]     m_velocity;
    logic                 m_index_seen;

    int fail_count;
    int outstanding;
    int compared;

    // sender-side view of the pins per axis (index 3 is the unused axis code)
    logic     lvl_a [4];
    logic     lvl_b [4];
    logic     lvl_z [4];
    logic     fwd_dir [4];
    logic [TW-1:0] clock_us;
    int       burst_left;
    int       words_sent;

    rx_mode_e    rx_mode;
    logic [31:0] rx_bits;
    int          rx_age;

    quadrature_position_velocity DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_axis       (s_axis),
        .s_sig_a      (s_sig_a),
        .s_sig_b      (s_sig_b),
        .s_sig_index  (s_sig_index),
        .s_time_us    (s_time_us),
        .s_vel_update (s_vel_update),
        .s_load_pos   (s_load_pos),
        .s_load_value (s_load_value),
        .s_take_index (s_take_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_axis   (m_out_axis),
        .m_position   (m_position),
        .m_velocity   (m_velocity),
        .m_index_seen (m_index_seen)
    );

    qpv_result_checker u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_axis       (s_axis),
        .s_sig_a      (s_sig_a),
        .s_sig_b      (s_sig_b),
        .s_sig_index  (s_sig_index),
        .s_time_us    (s_time_us),
        .s_vel_update (s_vel_update),
        .s_load_pos   (s_load_pos),
        .s_load_value (s_load_value),
        .s_take_index (s_take_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_axis   (m_out_axis),
        .m_position   (m_position),
        .m_velocity   (m_velocity),
        .m_index_seen (m_index_seen),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .compared     (compared)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver: draws a new stall pattern whenever rx_age runs out
    always @(negedge aclk) begin
        if (rx_age == 0) begin
            rx_mode = rx_mode_e'($urandom_range(0, 2));
            rx_bits = $urandom;
            rx_age  = 32;
        end
        rx_age--;
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_CHOPPY: m_ready <= rx_bits[rx_age];
            default:   m_ready <= (rx_age % 4 == 0);
        endcase
    end

    // Called at a falling edge; returns at a falling edge on which s_valid
    // has not been assigned yet.
    task automatic send_word(input logic [1:0] ax, input logic a, input logic b,
                             input logic z, input logic [TW-1:0] t, input logic vup,
                             input logic load, input logic [31:0] lval,
                             input logic take);
        s_valid      <= 1'b1;
        s_axis       <= ax;
        s_sig_a      <= a;
        s_sig_b      <= b;
        s_sig_index  <= z;
        s_time_us    <= t;
        s_vel_update <= vup;
        s_load_pos   <= load;
        s_load_value <= lval;
        s_take_index <= take;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        lvl_a[ax] = a;
        lvl_b[ax] = b;
        lvl_z[ax] = z;
        words_sent++;
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 8);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic run_random(input int count);
        int          done;
        logic [1:0]  ax;
        logic        a, b, z, vup, load, take;
        logic [31:0] lval;
        logic [63:0] jump;
        done = 0;
        while (done < count) begin
            case ($urandom_range(0, 49))
                0:       ;
                1:       clock_us -= TW'($urandom_range(1, 2000));
                2: begin
                    jump = {$urandom, $urandom};
                    clock_us += TW'(jump[46:0]);
                end
                3, 4:    clock_us += TW'($urandom_range(100000, 400000));
                default: clock_us += TW'($urandom_range(1, 400));
            endcase
            ax   = ($urandom_range(0, 39) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            vup  = ($urandom_range(0, 3) == 0);
            load = ($urandom_range(0, 24) == 0);
            take = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 3))
                0:       lval = 32'h7FFF_FFFF;
                1:       lval = 32'h8000_0000;
                default: lval = $urandom;
            endcase
            if ($urandom_range(0, 4) != 0) begin
                if ($urandom_range(0, 15) == 0) fwd_dir[ax] = ~fwd_dir[ax];
                a = lvl_a[ax];
                b = lvl_b[ax];
                if (fwd_dir[ax] ? (a == b) : (a != b)) a = ~a;
                else b = ~b;
                // short index pulses
                z = lvl_z[ax] ? ($urandom_range(0, 2) != 0) : ($urandom_range(0, 9) == 0);
            end else begin
                {a, b, z} = 3'($urandom_range(0, 7));
            end
            send_word(ax, a, b, z, clock_us, vup, load, lval, take);
            if (ax != 2'd3) done++;
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = REG_AXIS_ENABLE;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_axis       = '0;
        s_sig_a      = 1'b0;
        s_sig_b      = 1'b0;
        s_sig_index  = 1'b0;
        s_time_us    = '0;
        s_vel_update = 1'b0;
        s_load_pos   = 1'b0;
        s_load_value = '0;
        s_take_index = 1'b0;
        for (int i = 0; i < 4; i++) begin
            lvl_a[i]   = 1'b0;
            lvl_b[i]   = 1'b0;
            lvl_z[i]   = 1'b0;
            fwd_dir[i] = 1'b1;
        end
        clock_us   = '0;
        burst_left = 0;
        words_sent = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // axis 0: full forward cycle, index latch and take, zero and negative steps
        send_word(2'd0, 1, 0, 0, 48'd0,  0, 0, '0, 0);
        send_word(2'd0, 1, 1, 0, 48'd10, 0, 0, '0, 0);
        send_word(2'd0, 0, 1, 1, 48'd20, 0, 0, '0, 0);
        send_word(2'd0, 0, 0, 1, 48'd30, 1, 0, '0, 1);
        send_word(2'd0, 0, 0, 0, 48'd30, 1, 0, '0, 1);
        send_word(2'd0, 1, 1, 0, 48'd40, 0, 0, '0, 0);  // A and B together
        send_word(2'd0, 1, 0, 0, 48'd50, 0, 0, '0, 0);
        send_word(2'd0, 0, 0, 0, 48'd20, 1, 0, '0, 0);
        // axis 1: load with update, position wrap both ways, time wrap
        send_word(2'd1, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 1, 1, 32'h7FFF_FFFF, 0);
        send_word(2'd1, 1, 0, 0, 48'd5, 1, 0, '0, 0);
        send_word(2'd1, 1, 0, 0, 48'd6, 0, 1, 32'h8000_0000, 0);
        send_word(2'd1, 0, 0, 0, 48'd9, 1, 0, '0, 0);
        send_word(2'd3, 1, 1, 1, 48'hFFFF_FFFF_FFFF, 1, 1, 32'hFFFF_FFFF, 1);
        // axis 2: index rise and take in one word, reverse steps, huge step
        send_word(2'd2, 0, 0, 1, 48'd100, 0, 0, '0, 1);
        send_word(2'd2, 0, 0, 1, 48'd200, 0, 1, 32'hFFFF_FFFF, 1);
        send_word(2'd2, 0, 1, 0, 48'h8000_0000_0000, 1, 0, '0, 0);
        send_word(2'd2, 1, 1, 0, 48'h8000_0000_0001, 1, 0, '0, 0);
        send_word(2'd2, 1, 1, 0, 48'h8000_0000_0002, 1, 1, 32'h0, 0);
        drain();

        clock_us = 48'd1000;
        run_random(300);
        drain();
        write_reg(REG_AXIS_ENABLE, 24'd0);
        write_reg(REG_STILL_TIMEOUT, 24'd0);
        run_random(80);
        drain();
        write_reg(REG_AXIS_ENABLE, 24'd5);
        write_reg(REG_STILL_TIMEOUT, 24'hFF_FFFF);
        clock_us = 48'hFFFF_FFFF_F000;
        run_random(150);
        drain();
        write_reg(REG_AXIS_ENABLE, 24'd2);
        write_reg(REG_STILL_TIMEOUT, 24'($urandom_range(0, 300)));
        run_random(100);
        drain();
        write_reg(REG_AXIS_ENABLE, 24'd7);
        write_reg(REG_STILL_TIMEOUT, 24'($urandom_range(1000, 500000)));
        run_random(150);
        drain();

        $display("Summary: %0d sample words over five register settings, %0d results compared",
                 words_sent, compared);
        $display("Summary: directed edge, index, load and wrap cases, random traffic");
        if (fail_count == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/qpv_pkg.sv
hw/rtl/qpv_div.sv
hw/rtl/quadrature_position_velocity.sv
dv/qpv_result_checker.sv
dv/tb.sv
